/* src/pidc_pkg.sv */
`timescale 1ns / 1ps

package pidc_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_GAIN_PROP   = 3'd0;
    localparam logic [2:0] REG_GAIN_INTEG  = 3'd1;
    localparam logic [2:0] REG_GAIN_DERIV  = 3'd2;
    localparam logic [2:0] REG_PROP_LIMIT  = 3'd3;
    localparam logic [2:0] REG_INTEG_LIMIT = 3'd4;
    localparam logic [2:0] REG_DERIV_LIMIT = 3'd5;
    localparam logic [2:0] REG_DEADBAND    = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Operand pair routed to the shared multiplier
    typedef enum logic [2:0] {
        MUL_P,      // gain_prop  * error
        MUL_DT,     // error      * elapsed ticks
        MUL_D,      // gain_deriv * error change
        MUL_HI,     // |gain_integ| * |acc| upper part
        MUL_LO      // |gain_integ| * |acc| lower 32 bits
    } mul_sel_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        logic     cap_in;   // capture input transaction
        logic     ld_err;   // error and elapsed ticks
        logic     ld_chk;   // deadband flag and error change
        logic     ld_p;     // clamped P term
        logic     ld_acc;   // new accumulator value
        logic     ld_mag;   // D term, magnitudes, state commit
        logic     ld_pd;    // P + D
        logic     ld_hi;    // upper partial product check
        logic     ld_i;     // clipped I term
        logic     ld_sum;   // saturated sum
        logic     ld_out;   // load output register
    } cmd_t;

    typedef struct packed {
        logic dead;
        logic out_full;
    } sts_t;

endpackage

/* src/pidc_ctrl.sv */
`timescale 1ns / 1ps

module pidc_ctrl
    import pidc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic out_stall,
    input  sts_t sts,
    output logic in_stall,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_CHK,
        S_MDT,
        S_MD,
        S_MAG,
        S_MHI,
        S_MLO,
        S_ISUM,
        S_SUM,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_free;

    assign out_free = !sts.out_full || !out_stall;
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.mul_sel = MUL_P;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.cap_in = in_valid;
                if (in_valid)
                begin
                    state_next = S_ERR;
                end
            end
            S_ERR:
            begin
                cmd.ld_err = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                cmd.ld_chk  = 1'b1;
                cmd.mul_sel = MUL_P;
                state_next  = S_MDT;
            end
            S_MDT:
            begin
                // deadband flag became valid at the end of S_CHK
                if (sts.dead)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.ld_p    = 1'b1;
                    cmd.mul_sel = MUL_DT;
                    state_next  = S_MD;
                end
            end
            S_MD:
            begin
                cmd.ld_acc  = 1'b1;
                cmd.mul_sel = MUL_D;
                state_next  = S_MAG;
            end
            S_MAG:
            begin
                cmd.ld_mag = 1'b1;
                state_next = S_MHI;
            end
            S_MHI:
            begin
                cmd.ld_pd   = 1'b1;
                cmd.mul_sel = MUL_HI;
                state_next  = S_MLO;
            end
            S_MLO:
            begin
                cmd.ld_hi   = 1'b1;
                cmd.mul_sel = MUL_LO;
                state_next  = S_ISUM;
            end
            S_ISUM:
            begin
                cmd.ld_i   = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.ld_sum = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.ld_out = out_free;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* src/pidc_dp.sv */
`timescale 1ns / 1ps

module pidc_dp
    import pidc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic signed [23:0]      measured,
    input  logic signed [23:0]      target,
    input  logic [31:0]             timestamp,
    input  logic                    out_stall,
    input  cmd_t                    cmd,
    output sts_t                    sts,
    output logic signed [31:0]      drive,
    output logic                    in_deadband
);

    // config
    logic signed [31:0] gain_prop_reg;
    logic signed [31:0] gain_integ_reg;
    logic signed [31:0] gain_deriv_reg;
    logic [30:0]        prop_limit_reg;
    logic [30:0]        integ_limit_reg;
    logic [30:0]        deriv_limit_reg;
    logic [23:0]        deadband_reg;

    // controller state carried between samples
    logic signed [31:0] acc_reg;
    logic signed [24:0] last_err_reg;
    logic               last_neg_reg;
    logic [31:0]        last_time_reg;

    // per-sample work registers
    logic signed [23:0] meas_reg;
    logic signed [23:0] tgt_reg;
    logic [31:0]        ts_reg;
    logic signed [24:0] e_reg;
    logic [31:0]        dt_reg;
    logic               dead_reg;
    logic signed [25:0] de_reg;
    logic signed [65:0] prod_reg;
    logic signed [31:0] p_reg;
    logic signed [57:0] acc_new_reg;
    logic signed [31:0] d_reg;
    logic [57:0]        amag_reg;
    logic               aneg_reg;
    logic [31:0]        gmag_reg;
    logic               gneg_reg;
    logic signed [32:0] pd_reg;
    logic               hi_big_reg;
    logic [1:0]         hi_bits_reg;
    logic signed [35:0] iterm_reg;
    logic signed [31:0] sum_reg;

    logic signed [31:0] drive_reg;
    logic               db_reg;
    logic               out_full_reg;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic [24:0]        emag;
    logic               flip;
    logic signed [57:0] acc_sum;
    logic [34:0]        itot;
    logic               i_big;
    logic [34:0]        imag;
    logic signed [37:0] sum_wide;
    logic signed [31:0] sum_sat;

    function automatic logic signed [31:0] clamp_mag(input logic signed [65:0] v,
                                                     input logic [30:0] lim);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        begin
            hi = signed'({35'd0, lim});
            lo = -hi;
            if (v > hi)
                clamp_mag = signed'({1'b0, lim});
            else if (v < lo)
                clamp_mag = -signed'({1'b0, lim});
            else
                clamp_mag = v[31:0];
        end
    endfunction

    // operand routing for the one shared multiplier
    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_P:
            begin
                mul_a = {gain_prop_reg[31], gain_prop_reg};
                mul_b = {{8{e_reg[24]}}, e_reg};
            end
            MUL_DT:
            begin
                mul_a = {{8{e_reg[24]}}, e_reg};
                mul_b = {1'b0, dt_reg};
            end
            MUL_D:
            begin
                mul_a = {gain_deriv_reg[31], gain_deriv_reg};
                mul_b = {{7{de_reg[25]}}, de_reg};
            end
            MUL_HI:
            begin
                mul_a = {1'b0, gmag_reg};
                mul_b = {7'd0, amag_reg[57:32]};
            end
            MUL_LO:
            begin
                mul_a = {1'b0, gmag_reg};
                mul_b = {1'b0, amag_reg[31:0]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign emag    = e_reg[24] ? (~e_reg + 25'd1) : e_reg;
    assign flip    = e_reg[24] != last_neg_reg;
    assign acc_sum = {{26{acc_reg[31]}}, acc_reg} + prod_reg[57:0];

    // |I| = hi * 2^32 + lo; at or above 2^34 it saturates drive whatever P and D are
    assign itot  = {1'b0, hi_bits_reg, 32'd0} + {1'b0, prod_reg[33:0]};
    assign i_big = hi_big_reg || (|prod_reg[65:34]) || itot[34];
    assign imag  = i_big ? {1'b1, 34'd0} : itot;

    assign sum_wide = {{5{pd_reg[32]}}, pd_reg} + {{2{iterm_reg[35]}}, iterm_reg};

    always_comb
    begin
        priority if (!sum_wide[37] && (|sum_wide[36:31]))
            sum_sat = 32'sh7FFF_FFFF;
        else if (sum_wide[37] && !(&sum_wide[36:31]))
            sum_sat = 32'sh8000_0000;
        else
            sum_sat = sum_wide[31:0];
    end

    // config writes and cross-sample state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_prop_reg   <= '0;
            gain_integ_reg  <= '0;
            gain_deriv_reg  <= '0;
            prop_limit_reg  <= '1;
            integ_limit_reg <= '1;
            deriv_limit_reg <= '1;
            deadband_reg    <= '0;
            acc_reg         <= '0;
            last_err_reg    <= '0;
            last_neg_reg    <= 1'b0;
            last_time_reg   <= '0;
            out_full_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_GAIN_PROP:   gain_prop_reg   <= cfg_data;
                    REG_GAIN_INTEG:  gain_integ_reg  <= cfg_data;
                    REG_GAIN_DERIV:  gain_deriv_reg  <= cfg_data;
                    REG_PROP_LIMIT:  prop_limit_reg  <= cfg_data[30:0];
                    REG_INTEG_LIMIT: integ_limit_reg <= cfg_data[30:0];
                    REG_DERIV_LIMIT: deriv_limit_reg <= cfg_data[30:0];
                    REG_DEADBAND:    deadband_reg    <= cfg_data[23:0];
                    default: ;
                endcase
            end
            if (cmd.ld_mag)
            begin
                acc_reg       <= clamp_mag({{8{acc_new_reg[57]}}, acc_new_reg},
                                           integ_limit_reg);
                last_err_reg  <= e_reg;
                last_neg_reg  <= e_reg[24];
                last_time_reg <= ts_reg;
            end
            out_full_reg <= cmd.ld_out || (out_full_reg && out_stall);
        end
    end

    // work registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd.cap_in)
        begin
            meas_reg <= measured;
            tgt_reg  <= target;
            ts_reg   <= timestamp;
        end
        if (cmd.ld_err)
        begin
            e_reg  <= {tgt_reg[23], tgt_reg} - {meas_reg[23], meas_reg};
            dt_reg <= ts_reg - last_time_reg;
        end
        if (cmd.ld_chk)
        begin
            dead_reg <= emag <= {1'b0, deadband_reg};
            de_reg   <= {e_reg[24], e_reg} - {last_err_reg[24], last_err_reg};
        end
        if (cmd.ld_p)
        begin
            p_reg <= clamp_mag(prod_reg, prop_limit_reg);
        end
        if (cmd.ld_acc)
        begin
            acc_new_reg <= flip ? '0 : acc_sum;
        end
        if (cmd.ld_mag)
        begin
            d_reg    <= clamp_mag(prod_reg, deriv_limit_reg);
            amag_reg <= acc_new_reg[57] ? (~acc_new_reg + 58'd1) : acc_new_reg;
            aneg_reg <= acc_new_reg[57];
            gmag_reg <= gain_integ_reg[31] ? (~gain_integ_reg + 32'd1) : gain_integ_reg;
            gneg_reg <= gain_integ_reg[31];
        end
        if (cmd.ld_pd)
        begin
            pd_reg <= {p_reg[31], p_reg} + {d_reg[31], d_reg};
        end
        if (cmd.ld_hi)
        begin
            hi_big_reg  <= |prod_reg[65:2];
            hi_bits_reg <= prod_reg[1:0];
        end
        if (cmd.ld_i)
        begin
            iterm_reg <= (gneg_reg ^ aneg_reg) ? -signed'({1'b0, imag})
                                               : signed'({1'b0, imag});
        end
        if (cmd.ld_sum)
        begin
            sum_reg <= sum_sat;
        end
        if (cmd.ld_out)
        begin
            drive_reg <= dead_reg ? '0 : sum_reg;
            db_reg    <= dead_reg;
        end
    end

    assign sts.dead     = dead_reg;
    assign sts.out_full = out_full_reg;
    assign drive        = drive_reg;
    assign in_deadband  = db_reg;

endmodule

/* src/pid_step_with_clamps_deadband.sv */
`timescale 1ns / 1ps

// Channel  | Handshake            | Payload
// ---------+----------------------+-----------------------------------------
// input    | in_valid / in_stall  | measured[23:0] s, target[23:0] s,
//          |                      | timestamp[31:0]
// output   | out_valid / out_stall| drive[31:0] s (Q16.16), in_deadband
// config   | cfg_we               | cfg_index[2:0], cfg_data[31:0]
//
// One transaction at a time: a new sample is accepted only once the current
// one is done, and one inside the deadband skips the remaining product steps.
// The pace is set by the single shared 33x33 multiplier, used five times.
// Reset (rst_n low, async) clears the integrator state and the config
// registers to their defaults; no clearing pass is needed.
// A held output register lets the next sample be accepted while a result
// waits; the controller only stalls at the end if that register is still full.

module pid_step_with_clamps_deadband
    import pidc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [23:0]      measured,
    input  logic signed [23:0]      target,
    input  logic [31:0]             timestamp,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [31:0]      drive,
    output logic                    in_deadband
);

    cmd_t cmd;
    sts_t sts;

    // sequencer: steps the datapath through the P, I and D products
    pidc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .in_stall  (in_stall),
        .cmd       (cmd)
    );

    // datapath: config, integrator state, shared multiplier, output register
    pidc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .measured    (measured),
        .target      (target),
        .timestamp   (timestamp),
        .out_stall   (out_stall),
        .cmd         (cmd),
        .sts         (sts),
        .drive       (drive),
        .in_deadband (in_deadband)
    );

    assign out_valid = sts.out_full;

    // an accepted transaction makes the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after accept");

    // a result is only loaded into a free or draining output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ld_out |-> (!out_valid || !out_stall))
        else $error("output register overwritten while held");

    // a loaded result is presented on the next cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ld_out |=> out_valid)
        else $error("loaded result not presented");

    // deadband results carry a zero drive
    a_deadband_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && in_deadband) |-> (drive == 32'sd0))
        else $error("nonzero drive inside deadband");

endmodule

/* sim/pid_step_with_clamps_deadband_tb.sv */
`timescale 1ns / 1ps

module pid_step_with_clamps_deadband_tb;
    import pidc_pkg::*;

    // Index beyond the register file: the block must drop writes to it
    localparam logic [2:0] REG_UNUSED = 3'd7;

    // Clamp of |gain_integ * accumulator| before the final sum
    localparam longint I_TERM_SAT = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam longint DRIVE_MAX  = 64'sd2147483647;
    localparam longint DRIVE_MIN  = -64'sd2147483648;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 205;
    localparam int SETTLE_CYCLES   = 16;   // longer than an active transaction

    typedef struct {
        logic signed [31:0] drive;
        logic               dead;
    } drive_result_t;

    // Predicts drive / in_deadband per accepted sample and checks results
    // in order. Keeps its own copy of the registers and integrator state.
    class drive_scoreboard;
        longint kp = 0;
        longint ki = 0;
        longint kd = 0;
        longint p_lim = 64'h7FFF_FFFF;
        longint i_lim = 64'h7FFF_FFFF;
        longint d_lim = 64'h7FFF_FFFF;
        longint db_lim = 0;

        longint      integ_acc  = 0;
        longint      prev_err   = 0;
        bit          prev_neg   = 1'b0;
        logic [31:0] last_tick  = '0;

        drive_result_t expected_q[$];
        int            errors = 0;

        function void set_register(logic [2:0] idx, logic [31:0] data);
            case (idx)
                REG_GAIN_PROP:   kp = longint'(signed'(data));
                REG_GAIN_INTEG:  ki = longint'(signed'(data));
                REG_GAIN_DERIV:  kd = longint'(signed'(data));
                REG_PROP_LIMIT:  p_lim = longint'(data[30:0]);
                REG_INTEG_LIMIT: i_lim = longint'(data[30:0]);
                REG_DERIV_LIMIT: d_lim = longint'(data[30:0]);
                REG_DEADBAND:    db_lim = longint'(data[23:0]);
                default: ;
            endcase
        endfunction

        function longint clamp_mag(longint v, longint lim);
            if (v > lim)
                return lim;
            if (v < -lim)
                return -lim;
            return v;
        endfunction

        function void note_sample(logic signed [23:0] meas, logic signed [23:0] tgt,
                                  logic [31:0] ts);
            longint        err;
            longint        err_mag;
            longint        p_term;
            longint        i_term;
            longint        d_term;
            longint        total;
            logic [31:0]   dt;
            logic [63:0]   g_mag;
            logic [63:0]   a_mag;
            logic [127:0]  prod;
            bit            neg;
            drive_result_t res;

            err     = longint'(tgt) - longint'(meas);
            err_mag = (err < 0) ? -err : err;

            // inside the deadband: zero drive, state untouched
            if (err_mag <= db_lim)
            begin
                res.drive = '0;
                res.dead  = 1'b1;
                expected_q.push_back(res);
                return;
            end

            p_term = clamp_mag(kp * err, p_lim);

            dt = ts - last_tick;
            integ_acc = integ_acc + err * longint'(dt);
            neg = (err < 0);
            if (neg != prev_neg)
                integ_acc = 0;
            prev_neg = neg;

            // saturating Ki * acc, formed before the stored acc is clamped
            g_mag = (ki < 0) ? -ki : ki;
            a_mag = (integ_acc < 0) ? -integ_acc : integ_acc;
            prod  = {64'd0, g_mag} * {64'd0, a_mag};
            if (prod > I_TERM_SAT)
                prod = I_TERM_SAT;
            i_term = ((ki < 0) != (integ_acc < 0)) ? -longint'(prod[63:0])
                                                   : longint'(prod[63:0]);
            integ_acc = clamp_mag(integ_acc, i_lim);
            last_tick = ts;

            d_term = clamp_mag(kd * (err - prev_err), d_lim);
            prev_err = err;

            total = p_term + i_term + d_term;
            if (total > DRIVE_MAX)
                total = DRIVE_MAX;
            if (total < DRIVE_MIN)
                total = DRIVE_MIN;

            res.drive = total[31:0];
            res.dead  = 1'b0;
            expected_q.push_back(res);
        endfunction

        function void check_drive(logic signed [31:0] drive_got, logic dead_got);
            drive_result_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result drive=%0d in_deadband=%0b",
                         $time, drive_got, dead_got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (drive_got !== want.drive)
            begin
                $display("%0t: drive expected %0d actual %0d",
                         $time, want.drive, drive_got);
                errors++;
            end
            if (dead_got !== want.dead)
            begin
                $display("%0t: in_deadband expected %0b actual %0b",
                         $time, want.dead, dead_got);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic signed [23:0]    measured;
    logic signed [23:0]    target;
    logic [31:0]           timestamp;
    logic                  out_valid;
    logic                  out_stall;
    logic signed [31:0]    drive;
    logic                  in_deadband;

    drive_scoreboard sb = new();

    // Idling profile: 0 none, 1 sender gaps, 2 receiver stalls, 3 both light
    int          idle_mode = 0;
    int          cur_deadband = 0;   // tracks register for stimulus shaping
    int          setpoint = 0;
    logic [31:0] tick_now = '0;

    pid_step_with_clamps_deadband DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .measured    (measured),
        .target      (target),
        .timestamp   (timestamp),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .drive       (drive),
        .in_deadband (in_deadband)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic bit roll(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic int send_gap_pct();
        return (idle_mode == 1) ? 56 : (idle_mode == 3) ? 18 : 0;
    endfunction

    function automatic int recv_stall_pct();
        return (idle_mode == 2) ? 56 : (idle_mode == 3) ? 18 : 0;
    endfunction

    // Output side: check at the rising edge, pick the next stall at the falling one
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_drive(drive, in_deadband);
            @(negedge clk);
            out_stall <= roll(recv_stall_pct());
        end
    end

    // Entered at a falling edge; returns at the falling edge after the
    // transaction is taken, with in_valid still high so that a following
    // sample continues without a gap.
    task automatic send_sample(input logic signed [23:0] meas,
                               input logic signed [23:0] tgt,
                               input logic [31:0] ts);
        while (roll(send_gap_pct()))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        measured  <= meas;
        target    <= tgt;
        timestamp <= ts;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
            @(negedge clk);
        end
        sb.note_sample(meas, tgt, ts);
        @(negedge clk);
    endtask

    // Sender goes quiet until every pending result is back, then settles
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_register(idx, data);
        @(negedge clk);
    endtask

    // Only called with the block idle
    task automatic apply_config(input logic [31:0] kp, input logic [31:0] ki,
                                input logic [31:0] kd, input logic [31:0] plim,
                                input logic [31:0] ilim, input logic [31:0] dlim,
                                input logic [31:0] db);
        write_reg(REG_UNUSED, $urandom);
        write_reg(REG_GAIN_PROP, kp);
        write_reg(REG_GAIN_INTEG, ki);
        write_reg(REG_GAIN_DERIV, kd);
        write_reg(REG_PROP_LIMIT, plim);
        write_reg(REG_INTEG_LIMIT, ilim);
        write_reg(REG_DERIV_LIMIT, dlim);
        write_reg(REG_DEADBAND, db);
        cfg_we <= 1'b0;
        cur_deadband = int'(db[23:0]);
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_gain();
        logic [31:0] g;
        case ($urandom_range(0, 5))
            0: g = $urandom;
            1: g = '0;
            default:
            begin
                g = $urandom_range(0, 32'h0004_0000);
                if (roll(50))
                    g = -g;
            end
        endcase
        return g;
    endfunction

    function automatic logic [31:0] pick_limit();
        case ($urandom_range(0, 4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h0;
            2: return $urandom;   // upper bit is dropped by the register
            default: return $urandom_range(32'h0001_0000, 32'h0400_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_deadband();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return $urandom;
            default: return $urandom_range(0, 2000);
        endcase
    endfunction

    function automatic bit fits24(int v);
        return (v >= -8388608) && (v <= 8388607);
    endfunction

    function automatic int extreme24();
        case ($urandom_range(0, 3))
            0: return -8388608;
            1: return 8388607;
            2: return 0;
            default: return -1;
        endcase
    endfunction

    // Mostly a slowly moving setpoint with errors around the deadband edge
    // and a tick count that advances; some full-range and extreme samples.
    task automatic random_sample(output logic signed [23:0] meas,
                                 output logic signed [23:0] tgt,
                                 output logic [31:0] ts);
        logic [23:0] r_meas;
        logic [23:0] r_tgt;
        int          t;
        int          m;
        int          off;
        r_meas = 24'($urandom);
        r_tgt  = 24'($urandom);
        if (roll(3))
            setpoint = $urandom_range(0, 200000) - 100000;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                t = int'(signed'(r_tgt));
                m = int'(signed'(r_meas));
            end
            6:
            begin
                // right at or just past the deadband edge, either sign
                off = cur_deadband + $urandom_range(0, 1);
                t = $urandom_range(0, 2000) - 1000;
                m = roll(50) ? t - off : t + off;
            end
            7:
            begin
                t = extreme24();
                m = extreme24();
            end
            default:
            begin
                off = $urandom_range(0, cur_deadband + 3000);
                t = setpoint;
                m = roll(50) ? t - off : t + off;
            end
        endcase
        if (!fits24(m))
            m = t;
        if (roll(10))
            tick_now = $urandom;
        else
            tick_now = tick_now + $urandom_range(0, 2000);
        meas = m[23:0];
        tgt  = t[23:0];
        ts   = tick_now;
    endtask

    initial
    begin
        logic signed [23:0] s_meas;
        logic signed [23:0] s_tgt;
        logic [31:0]        s_ts;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        measured  = '0;
        target    = '0;
        timestamp = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: moderate gains, deadband of 100
        idle_mode = 0;
        apply_config(32'h0001_0000, 32'h0000_0100, 32'h0000_8000, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd100);
        send_sample(24'sd0, -24'sd1000, 32'd50);          // first active, negative
        send_sample(24'sd0, 24'sd0, 32'd60);              // zero error
        send_sample(24'sd0, 24'sd100, 32'd70);            // exactly on the deadband
        send_sample(24'sd0, -24'sd101, 32'd80);           // just outside
        send_sample(24'sd0, 24'sd101, 32'd90);            // sign flip
        send_sample(-24'sd8388608, 24'sd8388607, 32'hFFFF_FFFF);
        send_sample(24'sd8388607, -24'sd8388608, 32'd5);  // tick count wrapped
        send_sample(24'sd8388607, 24'sd8388607, 32'd6);
        send_sample(-24'sd8388608, -24'sd8388608, 32'd7);
        send_sample(24'sd12345, 24'sd20000, 32'd100);
        drain();

        // Largest gains: integral product and output both saturate
        apply_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0);
        send_sample(-24'sd8388608, 24'sd8388607, 32'h8000_0000);
        send_sample(-24'sd8388608, 24'sd8388607, 32'hFFFF_FFFF);
        send_sample(24'sd8388607, -24'sd8388608, 32'h0000_0010);
        send_sample(24'sd0, 24'sd1, 32'h0000_0020);
        send_sample(24'sd0, -24'sd1, 32'h0000_0030);
        drain();

        // Widest deadband swallows every possible error
        apply_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                     32'h0, 32'h0, 32'h00FF_FFFF);
        send_sample(-24'sd8388608, 24'sd8388607, 32'd40);
        send_sample(24'sd8388607, -24'sd8388608, 32'd41);
        drain();

        // All clamps at zero
        apply_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                     32'h0, 32'h0, 32'h0);
        send_sample(24'sd0, 24'sd5000, 32'd1000);
        send_sample(24'sd0, 24'sd6000, 32'd2000);
        send_sample(24'sd0, -24'sd3, 32'd2500);
        drain();

        // Random phases, each with its own settings and idling profile
        for (int ph = 0; ph < PHASES; ph++)
        begin
            idle_mode = ph % 4;
            if (ph == 0)
                apply_config(pick_gain(), pick_gain(), pick_gain(), 32'h7FFF_FFFF,
                             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
            else
                apply_config(pick_gain(), pick_gain(), pick_gain(), pick_limit(),
                             pick_limit(), pick_limit(), pick_deadband());
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                random_sample(s_meas, s_tgt, s_ts);
                send_sample(s_meas, s_tgt, s_ts);
                // now and then let the pipeline empty completely
                if (roll(1))
                    drain();
            end
            drain();
        end

        if (sb.errors == 0)
            $display("pid_step_with_clamps_deadband: match");
        else
            $display("pid_step_with_clamps_deadband: mismatch");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #4000000;
        $display("pid_step_with_clamps_deadband: mismatch");
        $finish;
    end

endmodule

/* sim.f */
src/pidc_pkg.sv
src/pidc_ctrl.sv
src/pidc_dp.sv
src/pid_step_with_clamps_deadband.sv
sim/pid_step_with_clamps_deadband_tb.sv
